>>> src/array_priority_queue_top_defines.svh
// Assertion macros used by the checker file.
`ifndef ARRAY_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define ARRAY_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define APQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apq assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define APQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apq assertion failed");

`endif

>>> src/apq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package apq_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int PRIO_BITS_DEF = 8;
    localparam int DATA_BITS_DEF = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic en;
        logic first;
    } best_ctl_t;

endpackage

`default_nettype wire

>>> src/apq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface apq_in_if
    import apq_pkg::*;
#(
    parameter int PRIO_BITS = PRIO_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [PRIO_BITS-1:0]        priority_req;
    logic signed [DATA_BITS-1:0] payload;

    modport source (output valid, output cmd, output priority_req, output payload,
                    input ready);
    modport sink (input valid, input cmd, input priority_req, input payload,
                  output ready);
    modport monitor (input valid, input ready, input cmd, input priority_req,
                     input payload);
endinterface

`default_nettype wire

>>> src/apq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface apq_out_if
    import apq_pkg::*;
#(
    parameter int PRIO_BITS = PRIO_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF,
    parameter int FILL_BITS = $clog2(SLOTS_DEF + 1)
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [PRIO_BITS-1:0]        out_priority;
    logic signed [DATA_BITS-1:0] out_payload;
    logic [FILL_BITS-1:0]        fill_level;

    modport source (output valid, output status, output out_priority,
                    output out_payload, output fill_level, input ready);
    modport sink (input valid, input status, input out_priority,
                  input out_payload, input fill_level, output ready);
    modport monitor (input valid, input ready, input status, input out_priority,
                     input out_payload, input fill_level);
endinterface

`default_nettype wire

>>> src/array_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Priority queue of SLOTS entries held in one RAM in arrival order (slot 0 oldest).
// Insert, insert-when-full and remove-when-empty return their result in the cycle after
// the transaction. A remove reads the held entries one per cycle from the RAM into a
// single comparator, sets up the move, moves each entry younger than the winner down
// one slot through the same read port, and then loads the result. The slowest remove
// is a full store with the winner at slot 0; a loaded result then waits until the
// sink takes it.
// The input is not ready while a remove is in progress or while a result waits for
// the sink. Result status: ok, full (insert dropped) or empty; fill_level is the
// count held after the operation.
module array_priority_queue_top
    import apq_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    apq_in_if.sink    in_ch,
    apq_out_if.source out_ch
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = PRIO_BITS + DATA_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SETUP,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        issue_reg, issue_next;
    logic [IW-1:0]        pend_idx_reg, pend_idx_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic                 out_vld_reg, out_vld_next;
    status_t              out_status_reg, out_status_next;
    logic [PRIO_BITS-1:0] out_prio_reg, out_prio_next;
    logic [DATA_BITS-1:0] out_data_reg, out_data_next;
    logic [CW-1:0]        out_fill_reg, out_fill_next;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic                 ram_re;
    logic [IW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;

    best_ctl_t            best_ctl;
    logic [PRIO_BITS-1:0] best_prio;
    logic [DATA_BITS-1:0] best_data;
    logic [IW-1:0]        best_idx;

    logic                 in_fire;
    logic                 out_free;
    logic                 last_pend;
    logic [CW-1:0]        shift_start;

    apq_ram #(
        .WIDTH(EW),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    apq_best #(
        .PRIO_BITS(PRIO_BITS),
        .DATA_BITS(DATA_BITS),
        .IDX_BITS (IW)
    ) u_best (
        .clk      (clk),
        .ctl      (best_ctl),
        .cand_prio(ram_rdata[EW-1:DATA_BITS]),
        .cand_data(ram_rdata[DATA_BITS-1:0]),
        .cand_idx (pend_idx_reg),
        .best_prio(best_prio),
        .best_data(best_data),
        .best_idx (best_idx)
    );

    assign out_free     = !out_vld_reg || out_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE) && out_free;
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign last_pend    = pend_vld_reg && (CW'(pend_idx_reg) == count_reg - CW'(1));
    assign shift_start  = CW'(best_idx) + CW'(1);

    assign best_ctl.en    = (state_reg == S_SCAN) && pend_vld_reg;
    assign best_ctl.first = (pend_idx_reg == '0);

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.out_priority = out_prio_reg;
    assign out_ch.out_payload  = out_data_reg;
    assign out_ch.fill_level   = out_fill_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_idx_next   = pend_idx_reg;
        pend_vld_next   = pend_vld_reg;
        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_prio_next   = out_prio_reg;
        out_data_next   = out_data_reg;
        out_fill_next   = out_fill_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = {in_ch.priority_req, in_ch.payload};
        ram_re          = 1'b0;
        ram_raddr       = issue_reg[IW-1:0];

        if (out_vld_reg && out_ch.ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_prio_next = '0;
                    out_data_next = '0;
                    if (in_ch.cmd == CMD_INSERT)
                    begin
                        out_vld_next = 1'b1;
                        if (count_reg == CW'(SLOTS))
                        begin
                            out_status_next = ST_FULL;
                            out_fill_next   = count_reg;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = count_reg[IW-1:0];
                            count_next      = count_reg + CW'(1);
                            out_status_next = ST_OK;
                            out_fill_next   = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_vld_next    = 1'b1;
                        out_status_next = ST_EMPTY;
                        out_fill_next   = '0;
                    end
                    else
                    begin
                        issue_next    = '0;
                        pend_vld_next = 1'b0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // read slot issue_reg now, compare it next cycle
                pend_vld_next = 1'b0;
                if (issue_reg < count_reg)
                begin
                    ram_re        = 1'b1;
                    issue_next    = issue_reg + CW'(1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = issue_reg[IW-1:0];
                end
                if (last_pend)
                begin
                    state_next = S_SETUP;
                end
            end

            S_SETUP:
            begin
                issue_next    = shift_start;
                pend_vld_next = 1'b0;
                if (shift_start >= count_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // read slot j, write it to slot j-1 next cycle
                pend_vld_next = 1'b0;
                if (issue_reg < count_reg)
                begin
                    ram_re        = 1'b1;
                    issue_next    = issue_reg + CW'(1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = issue_reg[IW-1:0];
                end
                if (pend_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg - IW'(1);
                    ram_wdata = ram_rdata;
                end
                if (last_pend)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = ST_OK;
                    out_prio_next   = best_prio;
                    out_data_next   = best_data;
                    out_fill_next   = count_reg - CW'(1);
                    count_next      = count_reg - CW'(1);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            issue_reg      <= '0;
            pend_idx_reg   <= '0;
            pend_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
            out_status_reg <= ST_OK;
            out_prio_reg   <= '0;
            out_data_reg   <= '0;
            out_fill_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            pend_idx_reg   <= pend_idx_next;
            pend_vld_reg   <= pend_vld_next;
            out_vld_reg    <= out_vld_next;
            out_status_reg <= out_status_next;
            out_prio_reg   <= out_prio_next;
            out_data_reg   <= out_data_next;
            out_fill_reg   <= out_fill_next;
        end
    end

endmodule

`default_nettype wire

>>> src/apq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module apq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/apq_best.sv
`timescale 1ns / 1ps
`default_nettype none

// Running maximum over the scanned entries; strict compare keeps the oldest on ties.
module apq_best
    import apq_pkg::*;
#(
    parameter int PRIO_BITS = PRIO_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF,
    parameter int IDX_BITS  = $clog2(SLOTS_DEF)
) (
    input  wire logic                 clk,
    input  wire best_ctl_t            ctl,
    input  wire logic [PRIO_BITS-1:0] cand_prio,
    input  wire logic [DATA_BITS-1:0] cand_data,
    input  wire logic [IDX_BITS-1:0]  cand_idx,
    output      logic [PRIO_BITS-1:0] best_prio,
    output      logic [DATA_BITS-1:0] best_data,
    output      logic [IDX_BITS-1:0]  best_idx
);

    logic take;

    assign take = ctl.en && (ctl.first || (cand_prio > best_prio));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_prio <= cand_prio;
            best_data <= cand_data;
            best_idx  <= cand_idx;
        end
    end

endmodule

`default_nettype wire

>>> src/apq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "array_priority_queue_top_defines.svh"

module apq_checker
    import apq_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         valid,
    input wire logic                         ready,
    input wire logic [1:0]                   status,
    input wire logic [PRIO_BITS-1:0]         out_priority,
    input wire logic [DATA_BITS-1:0]         out_payload,
    input wire logic [$clog2(SLOTS + 1)-1:0] fill_level
);

    logic no_entry;

    assign no_entry = (out_priority == '0) && (out_payload == '0);

    // a result waiting for the sink stays valid and holds its payload and fill level
    `APQ_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable(out_payload) && $stable(fill_level))

    `APQ_ASSERT_NOW(a_fill_range, valid, int'(fill_level) <= SLOTS)

    // dropped insert only when the store is full, and carries no entry
    `APQ_ASSERT_NOW(a_full_zero, valid && status == ST_FULL, int'(fill_level) == SLOTS && no_entry)

    `APQ_ASSERT_NOW(a_empty_zero, valid && status == ST_EMPTY, fill_level == '0 && no_entry)

endmodule

bind array_priority_queue_top apq_checker #(
    .SLOTS    (SLOTS),
    .PRIO_BITS(PRIO_BITS),
    .DATA_BITS(DATA_BITS)
) u_apq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (out_ch.valid),
    .ready       (out_ch.ready),
    .status      (out_ch.status),
    .out_priority(out_ch.out_priority),
    .out_payload (out_ch.out_payload),
    .fill_level  (out_ch.fill_level)
);

`default_nettype wire
